@@ rtl/effa_pkg.sv @@
// Shared types and constants of the extent first-fit allocator.
// Used by the controller, the datapath and the top level.
`default_nettype none
package effa_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int POS_BITS    = 32;
  localparam int LEN_BITS    = 32;
  localparam int REQ_LEN_BITS = 31;
  localparam int CAP_BITS    = 32;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 2);
  localparam int WC_W        = $clog2(MAX_EXTENTS + 3);
  localparam int EW          = POS_BITS + 1;
  localparam int STAT_BITS   = 3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_ZERO_LEN   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BUILD,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [POS_BITS-1:0] start;
    logic [LEN_BITS-1:0] len;
    logic                used;
  } entry_t;

  typedef struct packed {
    logic    accept;
    logic    scan;
    logic    prep;
    logic    build;
    logic    flush;
    logic    commit;
    logic    load_out;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic zero_len;
    logic is_release;
    logic scan_hit;
    logic scan_end;
    logic no_space;
    logic build_done;
    logic overflow;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/extent_first_fit_allocator_unit.sv @@
// Top level of the first-fit extent allocator with coalescing.
// Depends on effa_pkg, effa_ctrl and effa_datapath.
//
// Usage: one request on the in_ stream is an allocate (in_tuser = 0) or a
// release (in_tuser = 1) of a region; each request gives exactly one result
// on the out_ stream carrying a status code and the allocated position.
// cfg_we/cfg_wdata set the store capacity; write it only while idle.
// Throughput: one request at a time. A request scans the live extent bank
// entry by entry until the first fit (or the release match), then rebuilds
// the table into the other bank, copying each entry and putting the replaced
// extent in as up to three pieces, merging equal neighbours on the fly, then
// commits by swapping banks. An allocate with no fit is placed at the store
// end if the capacity allows. The table memory has a single read port.
// Reset (synchronous, rst_n low) empties the table, sets the store end to
// zero and the capacity to all ones; no clearing pass is needed.
// When the receiver stalls the result is held in the output register and
// the next request is taken, but its result waits until that one leaves.
`default_nettype none
module extent_first_fit_allocator_unit
  import effa_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // length[30:0], start_req[62:31], zero pad
  input  wire  [0:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // status[2:0], position[34:3], zero pad
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  logic [STAT_BITS-1:0] status;
  logic [POS_BITS-1:0]  position;

  effa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  effa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser[0]),
    .in_len     (in_tdata[REQ_LEN_BITS-1:0]),
    .in_start   (in_tdata[REQ_LEN_BITS+POS_BITS-1:REQ_LEN_BITS]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_pos    (position)
  );

  assign out_tdata = {5'd0, position, status};

endmodule
`default_nettype wire

@@ rtl/effa_ctrl.sv @@
// Sequencing state machine of the extent allocator.
// Depends on effa_pkg; drives the datapath by command and reads its status.
`default_nettype none
module effa_ctrl
  import effa_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.code  = code_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.zero_len) begin
          code_nxt  = ST_ZERO_LEN;
          state_nxt = S_DONE;
        end else if (sts.scan_hit) begin
          cmd.prep  = 1'b1;
          state_nxt = S_BUILD;
        end else if (sts.scan_end) begin
          if (sts.is_release) begin
            code_nxt  = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end else if (sts.no_space) begin
            code_nxt  = ST_NO_SPACE;
            state_nxt = S_DONE;
          end else begin
            cmd.prep  = 1'b1;
            state_nxt = S_BUILD;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_BUILD: begin
        if (sts.build_done) begin
          cmd.flush = 1'b1;
          state_nxt = S_COMMIT;
        end else begin
          cmd.build = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        code_nxt   = sts.overflow ? ST_TABLE_FULL : ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/effa_datapath.sv @@
// Extent table banks, scan compare, rebuild with merge and result register.
// Depends on effa_pkg; commanded by effa_ctrl.
`default_nettype none
module effa_datapath
  import effa_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  wire                          in_op,
  input  wire  [REQ_LEN_BITS-1:0]      in_len,
  input  wire  [POS_BITS-1:0]          in_start,
  input  wire                          cfg_we,
  input  wire  [CAP_BITS-1:0]          cfg_wdata,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [STAT_BITS-1:0]         out_status,
  output logic [POS_BITS-1:0]          out_pos
);

  entry_t mem0 [MAX_EXTENTS];
  entry_t mem1 [MAX_EXTENTS];
  entry_t rd_q_r;

  logic                bank_r, bank_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [POS_BITS-1:0] store_end_r, store_end_nxt;
  logic [CAP_BITS-1:0] cap_r, cap_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [CNT_W-1:0]    raddr_r, raddr_nxt;
  logic                ph_r, ph_nxt;

  logic                    op_r, op_nxt;
  logic [REQ_LEN_BITS-1:0] len_r, len_nxt;
  logic [POS_BITS-1:0]     sreq_r, sreq_nxt;
  logic [1:0]              pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]        rep_r, rep_nxt;
  entry_t                  pa_r, pa_nxt, pb_r, pb_nxt, pc_r, pc_nxt, pend_r, pend_nxt;
  logic                    pa_v_r, pa_v_nxt, pc_v_r, pc_v_nxt, app_r, app_nxt;
  logic [POS_BITS-1:0]     pos_r, pos_nxt, new_end_r, new_end_nxt;
  logic [WC_W-1:0]         wcnt_r, wcnt_nxt;
  logic [STAT_BITS-1:0]    ost_r, ost_nxt;
  logic [POS_BITS-1:0]     opos_r, opos_nxt;

  logic [LEN_BITS-1:0] len32;
  logic [EW-1:0]       q_end, req_end, app_end, lim;
  logic                eval, hit, stop, at_rep, em_v, wr_en;
  entry_t              em;

  assign len32   = LEN_BITS'({1'b0, len_r});
  assign q_end   = EW'(rd_q_r.start) + EW'(rd_q_r.len);
  assign req_end = EW'(sreq_r) + EW'(len32);
  assign app_end = EW'(store_end_r) + EW'(len32);
  assign lim     = (EW'(cap_r) > EW'({POS_BITS{1'b1}})) ? EW'({POS_BITS{1'b1}}) : EW'(cap_r);
  assign eval    = ph_r && (count_r != '0);
  assign hit     = op_r ? (rd_q_r.used && (rd_q_r.start <= sreq_r) && (q_end >= req_end))
                        : (!rd_q_r.used && (rd_q_r.len >= len32));
  assign stop    = op_r && (rd_q_r.start > sreq_r);
  assign at_rep  = (raddr_r == rep_r);

  always_comb begin
    sts            = '0;
    sts.zero_len   = (len_r == '0);
    sts.is_release = (op_r == OP_RELEASE);
    sts.scan_hit   = eval && hit;
    sts.scan_end   = (count_r == '0) ||
                     (eval && !hit && (stop || ((raddr_r + CNT_W'(1)) == count_r)));
    sts.no_space   = app_end > lim;
    sts.build_done = !at_rep && (raddr_r >= count_r);
    sts.overflow   = wcnt_r > WC_W'(MAX_EXTENTS);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    bank_nxt = bank_r; count_nxt = count_r; store_end_nxt = store_end_r; cap_nxt = cap_r;
    out_valid_nxt = out_valid_r; pend_v_nxt = pend_v_r; raddr_nxt = raddr_r; ph_nxt = ph_r;
    op_nxt = op_r; len_nxt = len_r; sreq_nxt = sreq_r; pcnt_nxt = pcnt_r; rep_nxt = rep_r;
    pa_nxt = pa_r; pb_nxt = pb_r; pc_nxt = pc_r; pend_nxt = pend_r;
    pa_v_nxt = pa_v_r; pc_v_nxt = pc_v_r; app_nxt = app_r;
    pos_nxt = pos_r; new_end_nxt = new_end_r; wcnt_nxt = wcnt_r;
    ost_nxt = ost_r; opos_nxt = opos_r;
    em_v = 1'b0; em = rd_q_r; wr_en = 1'b0;

    if (cfg_we) cap_nxt = cfg_wdata;

    if (cmd.accept) begin
      op_nxt = in_op; len_nxt = in_len; sreq_nxt = in_start;
      raddr_nxt = '0; ph_nxt = 1'b0;
    end

    if (cmd.scan) begin
      if (!ph_r) ph_nxt = 1'b1;
      else begin
        ph_nxt = 1'b0;
        raddr_nxt = raddr_r + CNT_W'(1);
      end
    end

    if (cmd.prep) begin
      raddr_nxt = '0; ph_nxt = 1'b0; pcnt_nxt = '0; pend_v_nxt = 1'b0; wcnt_nxt = '0;
      pa_v_nxt = 1'b0; pc_v_nxt = 1'b0;
      if (sts.scan_hit) begin
        rep_nxt = raddr_r; app_nxt = 1'b0;
        if (op_r == OP_RELEASE) begin
          pa_nxt   = '{start: rd_q_r.start, len: LEN_BITS'(sreq_r - rd_q_r.start), used: 1'b1};
          pa_v_nxt = (sreq_r != rd_q_r.start);
          pb_nxt   = '{start: sreq_r, len: len32, used: 1'b0};
          pc_nxt   = '{start: POS_BITS'(req_end), len: LEN_BITS'(q_end - req_end),
                       used: 1'b1};
          pc_v_nxt = q_end > req_end;
          pos_nxt  = '0;
        end else begin
          pb_nxt   = '{start: rd_q_r.start, len: len32, used: 1'b1};
          pc_nxt   = '{start: rd_q_r.start + POS_BITS'(len32), len: rd_q_r.len - len32,
                       used: 1'b0};
          pc_v_nxt = rd_q_r.len > len32;
          pos_nxt  = rd_q_r.start;
        end
      end else begin
        rep_nxt = count_r; app_nxt = 1'b1;
        pb_nxt = '{start: store_end_r, len: len32, used: 1'b1};
        pos_nxt = store_end_r;
        new_end_nxt = POS_BITS'(app_end);
      end
    end

    if (cmd.build) begin
      if (at_rep) begin
        case (pcnt_r)
          2'd0: begin
            em_v = pa_v_r; em = pa_r; pcnt_nxt = 2'd1;
          end
          2'd1: begin
            em_v = 1'b1; em = pb_r; pcnt_nxt = 2'd2;
          end
          default: begin
            em_v = pc_v_r; em = pc_r; pcnt_nxt = 2'd0;
            raddr_nxt = raddr_r + CNT_W'(1);
          end
        endcase
      end else if (!ph_r) begin
        ph_nxt = 1'b1;
      end else begin
        em_v = 1'b1; em = rd_q_r; ph_nxt = 1'b0;
        raddr_nxt = raddr_r + CNT_W'(1);
      end
      if (em_v) begin
        if (pend_v_r && (pend_r.used == em.used)) begin
          pend_nxt.len = pend_r.len + em.len;
        end else begin
          if (pend_v_r) begin
            wr_en = wcnt_r < WC_W'(MAX_EXTENTS);
            wcnt_nxt = wcnt_r + WC_W'(1);
          end
          pend_nxt = em; pend_v_nxt = 1'b1;
        end
      end
    end

    if (cmd.flush && pend_v_r) begin
      wr_en = wcnt_r < WC_W'(MAX_EXTENTS);
      wcnt_nxt = wcnt_r + WC_W'(1);
      pend_v_nxt = 1'b0;
    end

    if (cmd.commit && !sts.overflow) begin
      bank_nxt = !bank_r;
      count_nxt = CNT_W'(wcnt_r);
      if (app_r) store_end_nxt = new_end_r;
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      ost_nxt = cmd.code;
      opos_nxt = (cmd.code == ST_OK) ? pos_r : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= bank_r ? mem1[raddr_r[IDX_W-1:0]] : mem0[raddr_r[IDX_W-1:0]];
    if (wr_en) begin
      if (bank_r) mem0[wcnt_r[IDX_W-1:0]] <= pend_r;
      else        mem1[wcnt_r[IDX_W-1:0]] <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0; count_r <= '0; store_end_r <= '0; cap_r <= '1;
      out_valid_r <= 1'b0; pend_v_r <= 1'b0; raddr_r <= '0; ph_r <= 1'b0;
    end else begin
      bank_r <= bank_nxt; count_r <= count_nxt; store_end_r <= store_end_nxt;
      cap_r <= cap_nxt; out_valid_r <= out_valid_nxt; pend_v_r <= pend_v_nxt;
      raddr_r <= raddr_nxt; ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; len_r <= len_nxt; sreq_r <= sreq_nxt; pcnt_r <= pcnt_nxt;
    rep_r <= rep_nxt; pa_r <= pa_nxt; pb_r <= pb_nxt; pc_r <= pc_nxt; pend_r <= pend_nxt;
    pa_v_r <= pa_v_nxt; pc_v_r <= pc_v_nxt; app_r <= app_nxt; pos_r <= pos_nxt;
    new_end_r <= new_end_nxt; wcnt_r <= wcnt_nxt; ost_r <= ost_nxt; opos_r <= opos_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = ost_r;
  assign out_pos    = opos_r;

endmodule
`default_nettype wire

@@ test/effa_checker.sv @@
// Checker for the extent first-fit allocator: watches the request, result and
// capacity ports, predicts each result and compares. Depends on effa_pkg.
`default_nettype none
module effa_checker
  import effa_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [63:0] in_tdata,
  input  wire  [0:0]  in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [39:0] out_tdata,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct {
    status_t     code;
    logic [31:0] pos;
  } alloc_result_t;

  logic [63:0] ext_s[$];
  logic [63:0] ext_l[$];
  bit          ext_u[$];
  logic [63:0] tail_pos;
  logic [63:0] capacity;
  alloc_result_t expected_results[$];

  function automatic void merge_runs(ref logic [63:0] s[$], ref logic [63:0] l[$],
                                     ref bit u[$]);
    logic [63:0] ms[$];
    logic [63:0] ml[$];
    bit mu[$];
    int w;
    for (int i = 0; i < s.size(); i++) begin
      w = ms.size();
      if (w > 0 && mu[w-1] == u[i] && ms[w-1] + ml[w-1] == s[i]) begin
        ml[w-1] += l[i];
      end else begin
        ms.push_back(s[i]); ml.push_back(l[i]); mu.push_back(u[i]);
      end
    end
    s = ms; l = ml; u = mu;
  endfunction

  function automatic alloc_result_t predict_request(bit op, logic [63:0] len,
                                                    logic [63:0] sr);
    alloc_result_t r;
    logic [63:0] s[$];
    logic [63:0] l[$];
    bit u[$];
    logic [63:0] lim, off, b;
    int i;
    bit hit;
    r.code = ST_OK;
    r.pos  = '0;
    s = ext_s; l = ext_l; u = ext_u;
    if (len == 0) begin
      r.code = ST_ZERO_LEN;
      return r;
    end
    if (op == OP_ALLOC) begin
      hit = 0;
      for (i = 0; i < s.size(); i++) begin
        if (!u[i] && l[i] >= len) begin
          hit = 1;
          break;
        end
      end
      if (hit) begin
        b = s[i];
        if (l[i] > len) begin
          s.insert(i + 1, b + len); l.insert(i + 1, l[i] - len); u.insert(i + 1, 0);
        end
        u[i] = 1;
        l[i] = len;
        merge_runs(s, l, u);
        if (s.size() > MAX_EXTENTS) begin
          r.code = ST_TABLE_FULL;
          return r;
        end
        r.pos = b[31:0];
      end else begin
        lim = capacity;
        if (tail_pos + len > lim) begin
          r.code = ST_NO_SPACE;
          return r;
        end
        for (i = 0; i < s.size(); i++)
          if (s[i] > tail_pos) break;
        s.insert(i, tail_pos); l.insert(i, len); u.insert(i, 1);
        merge_runs(s, l, u);
        if (s.size() > MAX_EXTENTS) begin
          r.code = ST_TABLE_FULL;
          return r;
        end
        r.pos = tail_pos[31:0];
        tail_pos = tail_pos + len;
      end
    end else begin
      hit = 0;
      for (i = 0; i < s.size(); i++) begin
        if (u[i] && s[i] <= sr && s[i] + l[i] >= sr + len) begin
          hit = 1;
          break;
        end
        if (s[i] > sr) break;
      end
      if (!hit) begin
        r.code = ST_NOT_FOUND;
        return r;
      end
      off = sr - s[i];
      if (off > 0) begin
        s.insert(i, s[i]); l.insert(i, off); u.insert(i, 1);
        i++;
        s[i] += off;
        l[i] -= off;
      end
      u[i] = 0;
      if (l[i] > len) begin
        s.insert(i + 1, s[i] + len); l.insert(i + 1, l[i] - len); u.insert(i + 1, 1);
      end
      l[i] = len;
      merge_runs(s, l, u);
      if (s.size() > MAX_EXTENTS) begin
        r.code = ST_TABLE_FULL;
        return r;
      end
    end
    ext_s = s; ext_l = l; ext_u = u;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t e;
    bit bad;
    if (!rst_n) begin
      ext_s.delete(); ext_l.delete(); ext_u.delete();
      expected_results.delete();
      tail_pos      = '0;
      capacity     <= 64'hFFFF_FFFF;
      fail_count   <= 0;
      pending      <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) capacity <= {32'd0, cfg_wdata};
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_request(in_tuser[0], {33'd0, in_tdata[30:0]},
                                                   {32'd0, in_tdata[62:31]}));
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d position %0h",
                 out_tdata[2:0], out_tdata[34:3]);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          bad = 1'b0;
          if (out_tdata[2:0] !== e.code) begin
            $error("status: expected %0d, got %0d", e.code, out_tdata[2:0]);
            bad = 1'b1;
          end
          if (out_tdata[34:3] !== e.pos) begin
            $error("position: expected %0h, got %0h", e.pos, out_tdata[34:3]);
            bad = 1'b1;
          end
          if (bad) fail_count <= fail_count + 1;
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule
`default_nettype wire

@@ test/tb_extent_first_fit_allocator_unit.sv @@
// Top of the allocator testbench: drives requests, capacity writes and result
// back-pressure, and gives the verdict. Depends on effa_pkg and effa_checker.
`default_nettype none
module tb_extent_first_fit_allocator_unit;
  import effa_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  wire         in_tready;
  logic [63:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  wire         out_tvalid;
  logic        out_tready = 0;
  wire  [39:0] out_tdata;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count, pending, results_seen;
  int          idle_cycles = 0;
  int          sent = 0;
  logic [31:0] granted[$];

  localparam int IDLE_LIMIT = 20000;

  extent_first_fit_allocator_unit dut (.*);

  effa_checker chk (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic int gap_len();
    int k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // random back-pressure on results
  initial begin
    int g;
    @(posedge clk iff rst_n);
    forever begin
      g = (sent < 200) ? 0 : gap_len();
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  task automatic send_request(bit op, logic [30:0] len, logic [31:0] sr);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, sr, len};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_capacity(logic [31:0] v);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 0;
    granted.delete();
  endtask

  task automatic random_phase(int n, int maxlen);
    logic [31:0] p;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        send_request(OP_ALLOC, 31'($urandom_range(1, maxlen)), $urandom);
      end else if (k < 85 && granted.size() > 0) begin
        p = granted[$urandom_range(0, granted.size() - 1)];
        send_request(OP_RELEASE, 31'($urandom_range(1, maxlen)),
                     p + $urandom_range(0, maxlen / 2));
      end else if (k < 92) begin
        send_request(1'($urandom_range(0, 1)), 31'($urandom), $urandom);
      end else begin
        send_request(1'($urandom_range(0, 1)), 31'd0, $urandom);
      end
      if (out_tvalid && out_tdata[2:0] == ST_OK && out_tdata[34:3] != 0)
        granted.push_back(out_tdata[34:3]);
      if (granted.size() < 40) granted.push_back($urandom_range(0, maxlen * 40));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_RELEASE, 0, 32'hFFFF_FFFF);
    send_request(OP_RELEASE, 5, 0);
    send_request(OP_ALLOC, 31'h7FFF_FFFF, 0);
    send_request(OP_ALLOC, 31'h7FFF_FFFF, 0);
    send_request(OP_ALLOC, 2, 0);
    send_request(OP_RELEASE, 31'h7FFF_FFFF, 0);
    send_request(OP_ALLOC, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_RELEASE, 1, 32'h7FFF_FFFF);
    send_request(OP_RELEASE, 1, 32'hFFFF_FFFF);
    send_request(OP_RELEASE, 1, 32'hFFFF_FFFE);
    set_capacity(32'd1);
    send_request(OP_ALLOC, 1, 0);
    send_request(OP_ALLOC, 1, 0);
    set_capacity(32'd100000);
    // chop the store into single units then release alternate ones to fill the table
    for (int i = 0; i < 70; i++) send_request(OP_ALLOC, 1, 0);
    for (int i = 0; i < 140; i += 2) send_request(OP_RELEASE, 1, i);
    random_phase(150, 64);
    set_capacity(32'hFFFF_FFFF);
    random_phase(200, 5000);
    set_capacity(32'd3000);
    random_phase(200, 200);
    drain();
    $display("Run covered %0d requests and %0d results across four capacity settings.",
             sent, results_seen);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/effa_pkg.sv
rtl/effa_ctrl.sv
rtl/effa_datapath.sv
rtl/extent_first_fit_allocator_unit.sv
test/effa_checker.sv
test/tb_extent_first_fit_allocator_unit.sv
